@@ hw/rtl/elx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package elx_pkg;

    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_PUNCT  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam int unsigned RUN_MAX = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_tok;

    // Tokens closed by one text byte, in emission order.
    typedef struct packed {
        t_tok [RUN_MAX-1:0] tok;
        logic [2:0]         n;
    } t_run;

endpackage

`default_nettype wire

@@ hw/rtl/elx_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module elx_lexer import elx_pkg::*; #(
    parameter int unsigned MAX_TEXT_LEN = 65535
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_ch,
    output t_run            o_run
);

    localparam logic [15:0] POS_CAP =
        (MAX_TEXT_LEN < 32'd65535) ? 16'(MAX_TEXT_LEN) : 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_IDENT    = 4'd1,
        PH_STRING   = 4'd2,
        PH_NUM_INT  = 4'd3,
        PH_NUM_FRAC = 4'd4,
        PH_NUM_E1   = 4'd5,
        PH_NUM_E2   = 4'd6,
        PH_NUM_EXP  = 4'd7,
        PH_PUNCT    = 4'd8
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        in_str;
        logic [15:0] cur_start;
        logic [15:0] cur_len;
        logic [7:0]  la0;
        logic [7:0]  la1;
        logic [15:0] hp0;
        logic [15:0] hp1;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        t_tok       rec0;
        t_tok       rec1;
        logic [1:0] n;
        logic       ended;
        logic       relex;
    } t_lex_res;

    localparam t_lex_state LEX_RESET = '{
        phase: PH_IDLE, in_str: 1'b0, cur_start: 16'd0, cur_len: 16'd0,
        la0: 8'd0, la1: 8'd0, hp0: 16'd0, hp1: 16'd0
    };

    t_lex_state  r_st, n_st;
    logic [15:0] r_pos, n_pos;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
        logic p;
        p = 1'b0;
        if (b == "=") begin
            p = (a == "=") || (a == "!") || (a == ">") || (a == "<");
        end else if (b == "|") begin
            p = (a == "|");
        end else if (b == "&") begin
            p = (a == "&");
        end
        return p;
    endfunction

    function automatic t_lex_res emit(t_lex_res x, logic [1:0] kind, logic [15:0] start,
                                      logic [15:0] len);
        t_lex_res r;
        r = x;
        if (r.n == 2'd0) begin
            r.rec0 = '{kind: kind, start: start, len: len};
        end else begin
            r.rec1 = '{kind: kind, start: start, len: len};
        end
        r.n = r.n + 2'd1;
        return r;
    endfunction

    // One byte through the scanner. The failed exponent cases are only flagged
    // here; the caller replays the held bytes.
    function automatic t_lex_res lex_one(t_lex_state s, logic [7:0] c, logic [15:0] pos);
        t_lex_res r;
        logic     close;
        r       = '0;
        r.st    = s;
        close   = 1'b0;
        case (s.phase)
            PH_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    r.st.cur_len = sat_inc(s.cur_len);
                end else begin
                    r     = emit(r, KIND_IDENT, s.cur_start, s.cur_len);
                    close = 1'b1;
                end
            end
            PH_STRING: begin
                if (c != "\"" && c != 8'd0) begin
                    r.st.cur_len = sat_inc(s.cur_len);
                end else begin
                    r     = emit(r, KIND_IDENT, s.cur_start, s.cur_len);
                    close = 1'b1;
                end
            end
            PH_NUM_INT: begin
                if (is_digit(c)) begin
                    r.st.cur_len = sat_inc(s.cur_len);
                end else if (c == ".") begin
                    r.st.cur_len = sat_inc(s.cur_len);
                    r.st.phase   = PH_NUM_FRAC;
                end else begin
                    r     = emit(r, KIND_NUMBER, s.cur_start, s.cur_len);
                    close = 1'b1;
                end
            end
            PH_NUM_FRAC: begin
                if (is_digit(c)) begin
                    r.st.cur_len = sat_inc(s.cur_len);
                end else if (c == "e" || c == "E") begin
                    r.st.la0   = c;
                    r.st.hp0   = pos;
                    r.st.phase = PH_NUM_E1;
                end else begin
                    r     = emit(r, KIND_NUMBER, s.cur_start, s.cur_len);
                    close = 1'b1;
                end
            end
            PH_NUM_E1: begin
                if (is_digit(c) || c == "+" || c == "-") begin
                    r.st.la1   = c;
                    r.st.hp1   = pos;
                    r.st.phase = PH_NUM_E2;
                end else begin
                    r.relex = 1'b1;
                end
            end
            PH_NUM_E2: begin
                if (is_digit(c)) begin
                    r.st.cur_len = sat_inc(sat_inc(sat_inc(s.cur_len)));
                    r.st.phase   = PH_NUM_EXP;
                end else begin
                    r.relex = 1'b1;
                end
            end
            PH_NUM_EXP: begin
                if (is_digit(c)) begin
                    r.st.cur_len = sat_inc(s.cur_len);
                end else begin
                    r     = emit(r, KIND_NUMBER, s.cur_start, s.cur_len);
                    close = 1'b1;
                end
            end
            PH_PUNCT: begin
                if (is_pair(s.la0, c)) begin
                    r          = emit(r, KIND_PUNCT, s.cur_start, 16'd2);
                    r.st.phase = PH_IDLE;
                end else begin
                    r     = emit(r, KIND_PUNCT, s.cur_start, 16'd1);
                    close = 1'b1;
                end
            end
            default: begin
                close = 1'b1;
            end
        endcase

        if (close) begin
            r.st.phase = PH_IDLE;
            if (c == 8'd0) begin
                r       = emit(r, KIND_END, pos, 16'd0);
                r.ended = 1'b1;
            end else if (is_space(c)) begin
                r.st.phase = PH_IDLE;
            end else if (c == "\"") begin
                r.st.in_str = !s.in_str;
                r           = emit(r, KIND_PUNCT, pos, 16'd1);
            end else begin
                r.st.cur_start = pos;
                r.st.cur_len   = 16'd1;
                if (s.in_str) begin
                    r.st.phase = PH_STRING;
                end else if (is_alpha(c) || c == "_") begin
                    r.st.phase = PH_IDENT;
                end else if (is_digit(c)) begin
                    r.st.phase = PH_NUM_INT;
                end else if (c == ".") begin
                    r.st.phase = PH_NUM_FRAC;
                end else begin
                    r.st.phase = PH_PUNCT;
                    r.st.la0   = c;
                end
            end
        end
        return r;
    endfunction

    function automatic t_run push(t_run run, t_lex_res x);
        t_run r;
        r = run;
        if (x.n != 2'd0) begin
            r.tok[r.n[1:0]] = x.rec0;
            r.n             = r.n + 3'd1;
        end
        if (x.n == 2'd2) begin
            r.tok[r.n[1:0]] = x.rec1;
            r.n             = r.n + 3'd1;
        end
        return r;
    endfunction

    t_lex_res   w_first, w_held0, w_held1, w_last;
    t_lex_state w_idle;
    t_run       w_run;

    always_comb begin
        w_first      = lex_one(r_st, i_ch, r_pos);
        w_idle       = r_st;
        w_idle.phase = PH_IDLE;
        w_held0      = '0;
        w_held1      = '0;
        w_run        = '0;
        w_last       = w_first;
        if (w_first.relex) begin
            // The number ends before the e; the held bytes start over as new text.
            w_run   = '0;
            w_run.tok[0] = '{kind: KIND_NUMBER, start: r_st.cur_start, len: r_st.cur_len};
            w_run.n = 3'd1;
            w_held0 = lex_one(w_idle, r_st.la0, r_st.hp0);
            w_run   = push(w_run, w_held0);
            if (r_st.phase == PH_NUM_E2) begin
                w_held1 = lex_one(w_held0.st, r_st.la1, r_st.hp1);
                w_run   = push(w_run, w_held1);
                w_last  = lex_one(w_held1.st, i_ch, r_pos);
            end else begin
                w_last  = lex_one(w_held0.st, i_ch, r_pos);
            end
            w_run = push(w_run, w_last);
        end else begin
            w_run = push(w_run, w_first);
        end
    end

    assign o_run = w_run;

    always_comb begin
        if (w_last.ended) begin
            n_st  = LEX_RESET;
            n_pos = 16'd0;
        end else begin
            n_st  = w_last.st;
            n_pos = (r_pos < POS_CAP) ? r_pos + 16'd1 : r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= LEX_RESET;
            r_pos <= 16'd0;
        end else if (i_fire) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/elx_runbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module elx_runbuf import elx_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  t_run             i_run,
    output logic             o_free,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_start,
    output logic [15:0]      o_len,
    output logic             o_last
);

    t_tok [RUN_MAX-1:0] r_tok, n_tok;
    logic [2:0]         r_cnt, n_cnt;
    logic               w_pop;

    assign o_valid = (r_cnt != 3'd0);
    assign w_pop   = o_valid && i_ready;
    // A new run may be loaded once the word leaving this cycle is the last one.
    assign o_free  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && w_pop);

    assign o_kind  = r_tok[0].kind;
    assign o_start = r_tok[0].start;
    assign o_len   = r_tok[0].len;
    assign o_last  = (r_cnt == 3'd1);

    always_comb begin
        n_tok = r_tok;
        n_cnt = r_cnt;
        if (i_load) begin
            n_tok = i_run.tok;
            n_cnt = i_run.n;
        end else if (w_pop) begin
            for (int k = 0; k < RUN_MAX - 1; k++) begin
                n_tok[k] = r_tok[k+1];
            end
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/expression_lexer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Word
// input     i_in_valid / o_in_ready    i_ch
// output    o_out_valid / i_out_ready  o_token_kind, o_start_pos, o_token_len, o_last_of_run
//
// One text byte is taken per cycle while each byte closes at most one token and the
// output is ready; a byte that closes several tokens holds the next byte back until its last
// word leaves, as the result buffer hands out one word per cycle. A byte's first token
// passes the input register and result buffer. Reset is synchronous and needs no clearing
// pass. A stalled output keeps its word; the input register lets the next byte wait.

module expression_lexer_core import elx_pkg::*; #(
    parameter int unsigned MAX_TEXT_LEN = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_ch,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_token_kind,
    output logic [15:0]      o_start_pos,
    output logic [15:0]      o_token_len,
    output logic             o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       w_free, w_fire;
    t_run       w_run;

    assign w_fire     = r_in_valid && w_free;
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_ch <= i_ch;
        end
    end

    elx_lexer #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_ch   (r_in_ch),
        .o_run  (w_run)
    );

    elx_runbuf u_runbuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_fire),
        .i_run  (w_run),
        .o_free (w_free),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_kind (o_token_kind),
        .o_start(o_start_pos),
        .o_len  (o_token_len),
        .o_last (o_last_of_run)
    );

endmodule

`default_nettype wire

@@ test/expression_lexer_core_test.sv @@
`timescale 1ns / 1ps

module expression_lexer_core_test;
    import elx_pkg::*;

    localparam int unsigned TEXT_CAP = 65535;
    localparam logic [15:0] POS_LIMIT = (TEXT_CAP < 65535) ? 16'(TEXT_CAP) : 16'hFFFF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_E_LO  = "e";
    localparam logic [7:0] CH_E_UP  = "E";
    localparam logic [7:0] CH_A_LO  = "a";
    localparam logic [7:0] CH_A_UP  = "A";
    localparam logic [7:0] CH_ZERO  = "0";

    typedef enum logic [3:0] {
        LX_IDLE, LX_IDENT, LX_STRING, LX_INT, LX_FRAC,
        LX_E1, LX_E2, LX_EXP, LX_PUNCT
    } t_lex_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_ch = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_token_kind;
    logic [15:0] o_start_pos;
    logic [15:0] o_token_len;
    logic        o_last_of_run;

    expression_lexer_core #(.MAX_TEXT_LEN(TEXT_CAP)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_token_kind (o_token_kind),
        .o_start_pos  (o_start_pos),
        .o_token_len  (o_token_len),
        .o_last_of_run(o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    // Lexer state mirrored by the predictor.
    bit          in_quotes;
    t_lex_phase  phase;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] next_pos;
    logic [7:0]  held_ch [2];
    logic [15:0] held_at [2];
    bit          text_done;

    t_word       pending_tokens[$];
    t_word       byte_tokens[$];
    logic [7:0]  text_buf[$];
    t_word       got_tok;
    t_word       want_tok;

    string op_lead = "=!><|&+-*/(),;%^";
    string op_tail = "=|&";

    bit gaps_on = 1'b1;
    int mismatches = 0;
    int bytes_sent = 0;
    int stall_cycles = 0;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        return is_letter(c) || is_num(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_pair(input logic [7:0] a, input logic [7:0] b);
        if (b == CH_EQ) return a == CH_EQ || a == CH_BANG || a == CH_GT || a == CH_LT;
        if (b == CH_BAR) return a == CH_BAR;
        if (b == CH_AMP) return a == CH_AMP;
        return 1'b0;
    endfunction

    function automatic void lexer_reset();
        in_quotes = 1'b0;
        phase = LX_IDLE;
        tok_start = '0;
        tok_len = '0;
        next_pos = '0;
        held_ch[0] = '0;
        held_ch[1] = '0;
        held_at[0] = '0;
        held_at[1] = '0;
    endfunction

    function automatic void add_text(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void emit_token(input logic [1:0] kind, input logic [15:0] start,
                                       input logic [15:0] len);
        t_word t;
        if (byte_tokens.size() < RUN_MAX) begin
            t.kind = kind;
            t.start = start;
            t.len = len;
            t.last = 1'b0;
            byte_tokens.insert(byte_tokens.size(), t);
        end
    endfunction

    function automatic void open_token(input t_lex_phase ph, input logic [15:0] pos);
        phase = ph;
        tok_start = pos;
        tok_len = 16'd1;
    endfunction

    function automatic void begin_token(input logic [7:0] c, input logic [15:0] pos);
        phase = LX_IDLE;
        if (c == CH_END) begin
            emit_token(KIND_END, pos, 16'd0);
            text_done = 1'b1;
        end else if (is_blank(c)) begin
        end else if (c == CH_QUOTE) begin
            in_quotes = !in_quotes;
            emit_token(KIND_PUNCT, pos, 16'd1);
        end else if (in_quotes) begin
            open_token(LX_STRING, pos);
        end else if (is_letter(c) || c == CH_UNDER) begin
            open_token(LX_IDENT, pos);
        end else if (is_num(c)) begin
            open_token(LX_INT, pos);
        end else if (c == CH_DOT) begin
            open_token(LX_FRAC, pos);
        end else begin
            open_token(LX_PUNCT, pos);
            held_ch[0] = c;
        end
    endfunction

    // Extends or closes the open token; the failed-exponent paths are handled by
    // lex_byte before this is reached.
    function automatic void advance(input logic [7:0] c, input logic [15:0] pos);
        case (phase)
            LX_IDENT: begin
                if (is_word_char(c)) begin
                    tok_len = bump(tok_len);
                    return;
                end
                emit_token(KIND_IDENT, tok_start, tok_len);
            end
            LX_STRING: begin
                if (c != CH_QUOTE && c != CH_END) begin
                    tok_len = bump(tok_len);
                    return;
                end
                emit_token(KIND_IDENT, tok_start, tok_len);
            end
            LX_INT: begin
                if (is_num(c)) begin
                    tok_len = bump(tok_len);
                    return;
                end
                if (c == CH_DOT) begin
                    tok_len = bump(tok_len);
                    phase = LX_FRAC;
                    return;
                end
                emit_token(KIND_NUMBER, tok_start, tok_len);
            end
            LX_FRAC: begin
                if (is_num(c)) begin
                    tok_len = bump(tok_len);
                    return;
                end
                if (c == CH_E_LO || c == CH_E_UP) begin
                    held_ch[0] = c;
                    held_at[0] = pos;
                    phase = LX_E1;
                    return;
                end
                emit_token(KIND_NUMBER, tok_start, tok_len);
            end
            LX_E1: begin
                held_ch[1] = c;
                held_at[1] = pos;
                phase = LX_E2;
                return;
            end
            LX_E2: begin
                tok_len = bump(bump(bump(tok_len)));
                phase = LX_EXP;
                return;
            end
            LX_EXP: begin
                if (is_num(c)) begin
                    tok_len = bump(tok_len);
                    return;
                end
                emit_token(KIND_NUMBER, tok_start, tok_len);
            end
            LX_PUNCT: begin
                if (is_pair(held_ch[0], c)) begin
                    emit_token(KIND_PUNCT, tok_start, 16'd2);
                    phase = LX_IDLE;
                    return;
                end
                emit_token(KIND_PUNCT, tok_start, 16'd1);
            end
            default: begin
            end
        endcase
        begin_token(c, pos);
    endfunction

    // When the exponent falls through, the number closes before the e and the
    // held bytes are lexed again as fresh text, followed by the new byte.
    function automatic void lex_byte(input logic [7:0] c, input logic [15:0] pos);
        logic [7:0]  redo_ch [3];
        logic [15:0] redo_pos [3];
        int n;
        n = 1;
        redo_ch[0] = c;
        redo_pos[0] = pos;
        if (phase == LX_E1 && !(is_num(c) || c == CH_PLUS || c == CH_MINUS)) begin
            emit_token(KIND_NUMBER, tok_start, tok_len);
            phase = LX_IDLE;
            redo_ch[0] = held_ch[0];
            redo_pos[0] = held_at[0];
            redo_ch[1] = c;
            redo_pos[1] = pos;
            n = 2;
        end else if (phase == LX_E2 && !is_num(c)) begin
            emit_token(KIND_NUMBER, tok_start, tok_len);
            phase = LX_IDLE;
            redo_ch[0] = held_ch[0];
            redo_pos[0] = held_at[0];
            redo_ch[1] = held_ch[1];
            redo_pos[1] = held_at[1];
            redo_ch[2] = c;
            redo_pos[2] = pos;
            n = 3;
        end
        for (int k = 0; k < n; k++) advance(redo_ch[k], redo_pos[k]);
    endfunction

    function automatic void predict_tokens(input logic [7:0] c);
        t_word t;
        byte_tokens.delete();
        text_done = 1'b0;
        lex_byte(c, next_pos);
        if (text_done) begin
            lexer_reset();
        end else if (next_pos < POS_LIMIT) begin
            next_pos = next_pos + 16'd1;
        end
        if (byte_tokens.size() > 0) begin
            t = byte_tokens.pop_back();
            t.last = 1'b1;
            byte_tokens.insert(byte_tokens.size(), t);
        end
        for (int k = 0; k < byte_tokens.size(); k++)
            pending_tokens.insert(pending_tokens.size(), byte_tokens[k]);
    endfunction

    function automatic void log_mismatch(input bit unexpected, input t_word want,
                                         input t_word got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (unexpected)
                $display("%0t: unexpected word kind %0d start %0d len %0d last %0d",
                         $realtime, got.kind, got.start, got.len, got.last);
            else
                $display("%0t: word mismatch: kind %0d/%0d start %0d/%0d len %0d/%0d last %0d/%0d (exp/act)",
                         $realtime, want.kind, got.kind, want.start, got.start,
                         want.len, got.len, want.last, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_tok = {o_token_kind, o_start_pos, o_token_len, o_last_of_run};
            if (pending_tokens.size() == 0) begin
                log_mismatch(1'b1, '0, got_tok);
            end else begin
                want_tok = pending_tokens.pop_front();
                if (got_tok.kind !== want_tok.kind || got_tok.start !== want_tok.start ||
                    got_tok.len !== want_tok.len || got_tok.last !== want_tok.last)
                    log_mismatch(1'b0, want_tok, got_tok);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= !gaps_on || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        while (gaps_on && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        predict_tokens(c);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
        send_byte(CH_END);
    endtask

    task automatic send_buffer();
        while (text_buf.size() > 0) send_byte(text_buf.pop_front());
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        case ($urandom_range(0, lead ? 2 : 3))
            0: return 8'(CH_A_LO + $urandom_range(0, 25));
            1: return 8'(CH_A_UP + $urandom_range(0, 25));
            2: return CH_UNDER;
            default: return 8'(CH_ZERO + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) add_text(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void push_ident();
        add_text(word_char(1'b1));
        repeat ($urandom_range(0, 5)) add_text(word_char(1'b0));
    endfunction

    function automatic void push_number();
        bit dotted;
        int r;
        dotted = 1'b0;
        if ($urandom_range(0, 4) == 0) begin
            add_text(CH_DOT);
            dotted = 1'b1;
        end else begin
            push_digits($urandom_range(1, 3));
            if ($urandom_range(0, 9) < 6) begin
                add_text(CH_DOT);
                dotted = 1'b1;
            end
        end
        if (dotted) push_digits($urandom_range(0, 2));
        // Exponents are mostly complete, but a fair share stop after e or the sign.
        if (dotted ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0)) begin
            add_text($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
            r = $urandom_range(0, 5);
            if (r == 1) add_text(CH_PLUS);
            else if (r == 2) add_text(CH_MINUS);
            else if (r >= 3) push_digits(1);
            if (r != 0 && $urandom_range(0, 9) < 7) push_digits($urandom_range(1, 2));
        end
    endfunction

    function automatic void push_operator();
        if ($urandom_range(0, 5) == 0) begin
            add_text(8'($urandom_range(128, 255)));
        end else begin
            add_text(op_lead[$urandom_range(0, op_lead.len() - 1)]);
            if ($urandom_range(0, 1))
                add_text(op_tail[$urandom_range(0, op_tail.len() - 1)]);
        end
    endfunction

    function automatic void push_quoted();
        logic [7:0] b;
        add_text(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(1, 255));
            add_text((b == CH_QUOTE) ? CH_SPACE : b);
        end
        if ($urandom_range(0, 9) < 7) add_text(CH_QUOTE);
    endfunction

    function automatic void push_blank();
        int r;
        r = $urandom_range(8, 13);
        add_text((r == 8) ? CH_SPACE : 8'(r));
    endfunction

    // A text is a run of plausible tokens with some noise, closed by a zero byte.
    function automatic void build_text();
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_ident();
                3, 4:    push_number();
                5:       push_quoted();
                6, 7:    push_operator();
                8:       push_blank();
                default: add_text(8'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(0, 9) < 4) push_blank();
        end
        add_text(CH_END);
    endfunction

    task automatic test_mixed_operators();
        send_text("x_9>=.5e-7\"ab\"!=");
    endtask

    task automatic test_broken_exponents();
        send_text("1.e5");
        send_text(".E+");
    endtask

    task automatic test_high_bytes();
        send_byte(8'h80);
        send_byte(8'hFF);
        send_text("&&");
    endtask

    task automatic test_random_texts(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            build_text();
            send_buffer();
        end
    endtask

    task automatic test_drain_pause();
        build_text();
        send_buffer();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_tokens.size() != 0);
    endtask

    initial begin
        lexer_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_mixed_operators();
        test_broken_exponents();
        test_high_bytes();
        test_random_texts(160);
        test_drain_pause();
        gaps_on = 1'b0;
        test_random_texts(80);
        gaps_on = 1'b1;
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
